### sv/saw_arq_pkg.sv
// Shared types, codes and helpers for the stop-and-wait ARQ endpoint.
// Depends on nothing; every other file of the block imports it.
package saw_arq_pkg;

  localparam int SeqW = 32;
  localparam int TimerW = 16;
  localparam int RetryW = 4;
  localparam int CountW = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  localparam logic [RetryW-1:0] MaxRetriesReset = RetryW'(3);
  localparam logic [TimerW-1:0] AckTimeoutReset = TimerW'(500);
  localparam logic [TimerW-1:0] PeriodReset = TimerW'(1000);

  // Received packet types.
  typedef enum logic [1:0] {
    RX_TELEMETRY = 2'd0,
    RX_COMMAND   = 2'd1,
    RX_ACK       = 2'd2,
    RX_NAK       = 2'd3
  } rx_type_t;

  // Transmitted packet types.
  typedef enum logic [1:0] {
    TX_TELEMETRY = 2'd0,
    TX_ACK       = 2'd1,
    TX_NAK       = 2'd2
  } tx_type_t;

  // Outcome reported for a telemetry send.
  typedef enum logic [1:0] {
    OUTCOME_NONE      = 2'd0,
    OUTCOME_DELIVERED = 2'd1,
    OUTCOME_FAILED    = 2'd2
  } outcome_t;

  // Item kinds.
  typedef enum logic {
    KIND_TICK   = 1'b0,
    KIND_PACKET = 1'b1
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_RETRIES = 2'd0,
    CFG_ACK_TIMEOUT = 2'd1,
    CFG_PERIOD      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [RetryW-1:0] retry_limit;
    logic [TimerW-1:0] ack_wait_ticks;
    logic [TimerW-1:0] telemetry_period_ms;
  } cfg_t;

  typedef struct packed {
    logic             cmd;
    logic [1:0]       rx_type;
    logic [SeqW-1:0]  rx_seq;
    logic             rx_crc_ok;
    logic             rx_payload_ok;
    logic [1:0]       rx_command;
  } req_t;

  typedef struct packed {
    logic              tx_valid;
    logic [1:0]        tx_type;
    logic [SeqW-1:0]   tx_seq;
    logic [1:0]        send_outcome;
    logic              command_valid;
    logic [1:0]        command_code;
    logic [CountW-1:0] delivered_count;
    logic [CountW-1:0] resend_count;
    logic [CountW-1:0] nak_count;
    logic [CountW-1:0] accepted_count;
  } result_t;

  typedef struct packed {
    logic              waiting_ack;
    logic [TimerW-1:0] period_timer;
    logic [TimerW-1:0] timeout_timer;
    logic [RetryW-1:0] attempt_number;
    logic [SeqW-1:0]   next_tx_seq;
    logic [SeqW-1:0]   pending_seq;
    logic [SeqW-1:0]   expected_rx_seq;
    logic [CountW-1:0] delivered;
    logic [CountW-1:0] resends;
    logic [CountW-1:0] naks;
    logic [CountW-1:0] accepted;
  } arq_state_t;

  // Millisecond timers stop at their top value instead of wrapping.
  function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] v);
    logic [TimerW-1:0] r;
    r = (v == '1) ? v : v + TimerW'(1);
    return r;
  endfunction

endpackage

### sv/saw_arq_if.sv
// Handshake channels of the ARQ endpoint: input items, result items and
// configuration writes. Depends on saw_arq_pkg.
interface saw_arq_req_if import saw_arq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [1:0]       rx_type;
  logic [SeqW-1:0]  rx_seq;
  logic             rx_crc_ok;
  logic             rx_payload_ok;
  logic [1:0]       rx_command;

  modport source (output valid, cmd, rx_type, rx_seq, rx_crc_ok, rx_payload_ok,
                  rx_command, input ready);
  modport sink (input valid, cmd, rx_type, rx_seq, rx_crc_ok, rx_payload_ok,
                rx_command, output ready);
endinterface

interface saw_arq_rsp_if import saw_arq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              tx_valid;
  logic [1:0]        tx_type;
  logic [SeqW-1:0]   tx_seq;
  logic [1:0]        send_outcome;
  logic              command_valid;
  logic [1:0]        command_code;
  logic [CountW-1:0] delivered_count;
  logic [CountW-1:0] resend_count;
  logic [CountW-1:0] nak_count;
  logic [CountW-1:0] accepted_count;

  modport source (output valid, tx_valid, tx_type, tx_seq, send_outcome,
                  command_valid, command_code, delivered_count, resend_count,
                  nak_count, accepted_count, input ready);
  modport sink (input valid, tx_valid, tx_type, tx_seq, send_outcome,
                command_valid, command_code, delivered_count, resend_count,
                nak_count, accepted_count, output ready);
endinterface

interface saw_arq_cfg_if import saw_arq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/saw_arq_step.sv
// Next-state and result logic of the endpoint for one registered item.
// Purely combinational. Depends on saw_arq_pkg.
module saw_arq_step import saw_arq_pkg::*; (
  input  cfg_t       cfg_regs,
  input  arq_state_t st,
  input  req_t       item,
  output arq_state_t st_next,
  output result_t    res
);

  logic            fail;
  logic [TimerW-1:0] period_inc;
  logic [TimerW-1:0] timeout_inc;
  logic            seq_match;

  assign period_inc  = sat_inc(st.period_timer);
  assign timeout_inc = sat_inc(st.timeout_timer);
  assign seq_match   = (item.rx_seq == st.pending_seq);

  always_comb begin
    st_next = st;
    res = '0;
    fail = 1'b0;

    // Main decision: tick handling, waiting for an ack, or idle receive.
    if (item.cmd == KIND_TICK) begin
      st_next.period_timer = period_inc;
      if (st.waiting_ack) begin
        st_next.timeout_timer = timeout_inc;
        fail = (timeout_inc >= cfg_regs.ack_wait_ticks);
      end else if (period_inc >= cfg_regs.telemetry_period_ms) begin
        st_next.period_timer   = '0;
        st_next.pending_seq    = st.next_tx_seq;
        st_next.next_tx_seq    = st.next_tx_seq + SeqW'(1);
        st_next.attempt_number = '0;
        st_next.timeout_timer  = '0;
        st_next.waiting_ack    = 1'b1;
        res.tx_valid = 1'b1;
        res.tx_type  = TX_TELEMETRY;
        res.tx_seq   = st.next_tx_seq;
      end
    end else if (st.waiting_ack) begin
      if (item.rx_type == RX_ACK && seq_match) begin
        st_next.delivered   = st.delivered + CountW'(1);
        st_next.waiting_ack = 1'b0;
        res.send_outcome    = OUTCOME_DELIVERED;
      end else begin
        if (item.rx_type == RX_NAK && seq_match) begin
          st_next.naks = st.naks + CountW'(1);
        end
        fail = 1'b1;
      end
    end else if (!item.rx_crc_ok) begin
      res.tx_valid = 1'b1;
      res.tx_type  = TX_NAK;
      res.tx_seq   = item.rx_seq;
    end else if (item.rx_type == RX_COMMAND) begin
      res.tx_valid = 1'b1;
      res.tx_seq   = item.rx_seq;
      if (item.rx_seq < st.expected_rx_seq) begin
        // Duplicate of an older command: acknowledge again.
        res.tx_type = TX_ACK;
      end else begin
        st_next.expected_rx_seq = item.rx_seq + SeqW'(1);
        if (item.rx_payload_ok) begin
          st_next.accepted  = st.accepted + CountW'(1);
          res.command_valid = 1'b1;
          res.command_code  = item.rx_command;
          res.tx_type       = TX_ACK;
        end else begin
          res.tx_type = TX_NAK;
        end
      end
    end

    // A failed attempt resends while retries remain, otherwise gives up.
    if (fail) begin
      if (st.attempt_number < cfg_regs.retry_limit) begin
        st_next.attempt_number = st.attempt_number + RetryW'(1);
        st_next.resends        = st.resends + CountW'(1);
        st_next.timeout_timer  = '0;
        res.tx_valid = 1'b1;
        res.tx_type  = TX_TELEMETRY;
        res.tx_seq   = st.pending_seq;
      end else begin
        res.send_outcome    = OUTCOME_FAILED;
        st_next.waiting_ack = 1'b0;
      end
    end

    res.delivered_count = st_next.delivered;
    res.resend_count    = st_next.resends;
    res.nak_count       = st_next.naks;
    res.accepted_count  = st_next.accepted;
  end

endmodule

### sv/stop_and_wait_arq_endpoint.sv
// Top level of the stop-and-wait ARQ endpoint: channel registers, state and
// configuration registers. Depends on saw_arq_pkg, saw_arq_if and saw_arq_step.
//
// Usage:
//   req  carries one item per handshake: a millisecond tick (cmd 0) or the
//        header of a received packet (cmd 1).
//   rsp  returns exactly one result item per input item, in order: the packet
//        to transmit, if any, the telemetry send outcome, an accepted command
//        and the four running statistics.
//   cfg  writes the retry limit (index 0), the acknowledgment wait in ticks
//        (index 1) and telemetry_period_ms (index 2); other indexes are
//        ignored. It is always ready and should be used only while no item
//        is in flight.
// An accepted item sits in the input register while the step logic computes its
// result, which is then loaded into the result register once that register is
// free or draining. One item per cycle is sustained while the receiver takes
// results; the step logic computes all next state combinationally, so items
// follow each other back to back.
// Synchronous reset returns every timer, sequence number and counter to zero,
// the endpoint to idle and the registers to 3, 500 and 1000.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; req.ready then drops until rsp moves again.
module stop_and_wait_arq_endpoint import saw_arq_pkg::*; (
  input logic             clk,
  input logic             rst,
  saw_arq_req_if.sink     req,
  saw_arq_rsp_if.source   rsp,
  saw_arq_cfg_if.sink     cfg
);

  cfg_t       cfg_regs;
  arq_state_t st;
  arq_state_t st_next;
  req_t       item;
  logic       item_valid;
  result_t    res_next;
  result_t    res;
  logic       res_valid;
  logic       advance;
  req_t       req_payload;

  assign req_payload = '{cmd: req.cmd, rx_type: req.rx_type, rx_seq: req.rx_seq,
                         rx_crc_ok: req.rx_crc_ok, rx_payload_ok: req.rx_payload_ok,
                         rx_command: req.rx_command};

  // The registered item moves on when the result register is free or drains.
  assign advance   = item_valid && (!res_valid || rsp.ready);
  assign req.ready = !item_valid || advance;
  assign cfg.ready = 1'b1;

  saw_arq_step u_step (
    .cfg_regs (cfg_regs),
    .st       (st),
    .item     (item),
    .st_next  (st_next),
    .res      (res_next)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.retry_limit         <= MaxRetriesReset;
      cfg_regs.ack_wait_ticks      <= AckTimeoutReset;
      cfg_regs.telemetry_period_ms <= PeriodReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MAX_RETRIES: cfg_regs.retry_limit         <= cfg.data[RetryW-1:0];
        CFG_ACK_TIMEOUT: cfg_regs.ack_wait_ticks      <= cfg.data[TimerW-1:0];
        CFG_PERIOD:      cfg_regs.telemetry_period_ms <= cfg.data[TimerW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Endpoint state advances once per item taken from the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item <= req_payload;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign rsp.valid           = res_valid;
  assign rsp.tx_valid        = res.tx_valid;
  assign rsp.tx_type         = res.tx_type;
  assign rsp.tx_seq          = res.tx_seq;
  assign rsp.send_outcome    = res.send_outcome;
  assign rsp.command_valid   = res.command_valid;
  assign rsp.command_code    = res.command_code;
  assign rsp.delivered_count = res.delivered_count;
  assign rsp.resend_count    = res.resend_count;
  assign rsp.nak_count       = res.nak_count;
  assign rsp.accepted_count  = res.accepted_count;

endmodule

### tb/tb_stop_and_wait_arq_endpoint.sv
// Self-checking testbench for the stop-and-wait ARQ endpoint: directed link scenarios
// followed by random ticks and packet headers under several register settings.
// Depends on saw_arq_pkg, the saw_arq interfaces and stop_and_wait_arq_endpoint.
module tb_stop_and_wait_arq_endpoint;
  import saw_arq_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int StallLimit = 2000;
  localparam int ItemsPerPhase = 75;
  localparam int NumPhases = 8;

  // Tracks the endpoint's link state and holds the results it must produce, in order.
  class arq_link_checker;
    logic [RetryW-1:0] retry_limit;
    logic [TimerW-1:0] ack_timeout;
    logic [TimerW-1:0] period;
    bit                waiting;
    logic [TimerW-1:0] period_tmr;
    logic [TimerW-1:0] timeout_tmr;
    logic [RetryW-1:0] attempt;
    logic [SeqW-1:0]   next_seq;
    logic [SeqW-1:0]   pending_seq;
    logic [SeqW-1:0]   expected_rx;
    logic [CountW-1:0] delivered;
    logic [CountW-1:0] resends;
    logic [CountW-1:0] naks;
    logic [CountW-1:0] accepted;
    result_t           due_results[$];
    int                errors;
    int                checked;

    function new();
      retry_limit = MaxRetriesReset;
      ack_timeout = AckTimeoutReset;
      period = PeriodReset;
      waiting = 1'b0;
      period_tmr = '0;
      timeout_tmr = '0;
      attempt = '0;
      next_seq = '0;
      pending_seq = '0;
      expected_rx = '0;
      delivered = '0;
      resends = '0;
      naks = '0;
      accepted = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] d);
      case (idx)
        CFG_MAX_RETRIES: retry_limit = d[RetryW-1:0];
        CFG_ACK_TIMEOUT: ack_timeout = d;
        CFG_PERIOD:      period = d;
        default: ;
      endcase
    endfunction

    // Millisecond counters hold at their top value.
    function logic [TimerW-1:0] count_ms(input logic [TimerW-1:0] v);
      return (v == '1) ? v : v + TimerW'(1);
    endfunction

    function void transmit(inout result_t r, input tx_type_t t, input logic [SeqW-1:0] s);
      r.tx_valid = 1'b1;
      r.tx_type = t;
      r.tx_seq = s;
    endfunction

    // A lost attempt resends while retries remain, otherwise the send fails.
    function void attempt_lost(inout result_t r);
      if (attempt < retry_limit) begin
        attempt = attempt + RetryW'(1);
        resends = resends + CountW'(1);
        timeout_tmr = '0;
        transmit(r, TX_TELEMETRY, pending_seq);
      end else begin
        r.send_outcome = OUTCOME_FAILED;
        waiting = 1'b0;
      end
    endfunction

    // Works out the result of one accepted item and queues it.
    function void predict_item(input req_t it);
      result_t r;
      r = '0;
      if (it.cmd == KIND_TICK) begin
        period_tmr = count_ms(period_tmr);
        if (waiting) begin
          timeout_tmr = count_ms(timeout_tmr);
          if (timeout_tmr >= ack_timeout) attempt_lost(r);
        end else if (period_tmr >= period) begin
          period_tmr = '0;
          pending_seq = next_seq;
          next_seq = next_seq + SeqW'(1);
          attempt = '0;
          timeout_tmr = '0;
          waiting = 1'b1;
          transmit(r, TX_TELEMETRY, pending_seq);
        end
      end else if (waiting) begin
        // The checksum is not looked at while a telemetry send is outstanding.
        if (it.rx_type == RX_ACK && it.rx_seq == pending_seq) begin
          delivered = delivered + CountW'(1);
          r.send_outcome = OUTCOME_DELIVERED;
          waiting = 1'b0;
        end else begin
          if (it.rx_type == RX_NAK && it.rx_seq == pending_seq) naks = naks + CountW'(1);
          attempt_lost(r);
        end
      end else if (!it.rx_crc_ok) begin
        transmit(r, TX_NAK, it.rx_seq);
      end else if (it.rx_type == RX_COMMAND) begin
        if (it.rx_seq < expected_rx) begin
          transmit(r, TX_ACK, it.rx_seq);
        end else begin
          expected_rx = it.rx_seq + SeqW'(1);
          if (it.rx_payload_ok) begin
            accepted = accepted + CountW'(1);
            r.command_valid = 1'b1;
            r.command_code = it.rx_command;
            transmit(r, TX_ACK, it.rx_seq);
          end else begin
            transmit(r, TX_NAK, it.rx_seq);
          end
        end
      end
      r.delivered_count = delivered;
      r.resend_count = resends;
      r.nak_count = naks;
      r.accepted_count = accepted;
      due_results.push_back(r);
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH %s", msg);
      errors++;
    endtask

    task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                  checked, name, got, want));
    endtask

    task check_result(input result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
      end else begin
        want = due_results.pop_front();
        check_field("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
        check_field("tx_type", 32'(got.tx_type), 32'(want.tx_type));
        check_field("tx_seq", got.tx_seq, want.tx_seq);
        check_field("send_outcome", 32'(got.send_outcome), 32'(want.send_outcome));
        check_field("command_valid", 32'(got.command_valid), 32'(want.command_valid));
        check_field("command_code", 32'(got.command_code), 32'(want.command_code));
        check_field("delivered_count", got.delivered_count, want.delivered_count);
        check_field("resend_count", got.resend_count, want.resend_count);
        check_field("nak_count", got.nak_count, want.nak_count);
        check_field("accepted_count", got.accepted_count, want.accepted_count);
      end
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   n_sent = 0;
  int   idle_cycles = 0;
  arq_link_checker board = new();

  saw_arq_req_if req();
  saw_arq_rsp_if rsp();
  saw_arq_cfg_if cfg();

  stop_and_wait_arq_endpoint dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  always #(HalfPeriod) clk = ~clk;

  // The receiver stalls at random, at the rate the current phase sets.
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Observe every handshake at the rising edge.
  always @(posedge clk) begin
    result_t got;
    req_t    acc;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        got = '{tx_valid: rsp.tx_valid, tx_type: rsp.tx_type, tx_seq: rsp.tx_seq,
                send_outcome: rsp.send_outcome, command_valid: rsp.command_valid,
                command_code: rsp.command_code, delivered_count: rsp.delivered_count,
                resend_count: rsp.resend_count, nak_count: rsp.nak_count,
                accepted_count: rsp.accepted_count};
        board.check_result(got);
      end
      if (req.valid && req.ready) begin
        acc = '{cmd: req.cmd, rx_type: req.rx_type, rx_seq: req.rx_seq,
                rx_crc_ok: req.rx_crc_ok, rx_payload_ok: req.rx_payload_ok,
                rx_command: req.rx_command};
        board.predict_item(acc);
      end
      if (cfg.valid && cfg.ready) board.write_reg(cfg_idx_t'(cfg.index), cfg.data);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // A tick; the packet fields carry random junk that must be ignored.
  function automatic req_t tick();
    req_t it;
    it.cmd = KIND_TICK;
    it.rx_type = 2'($urandom_range(3));
    it.rx_seq = $urandom();
    it.rx_crc_ok = 1'($urandom_range(1));
    it.rx_payload_ok = 1'($urandom_range(1));
    it.rx_command = 2'($urandom_range(3));
    return it;
  endfunction

  function automatic req_t pkt(input rx_type_t t, input logic [SeqW-1:0] s, input bit crc,
                               input bit pay, input logic [1:0] code);
    return '{cmd: KIND_PACKET, rx_type: t, rx_seq: s, rx_crc_ok: crc,
             rx_payload_ok: pay, rx_command: code};
  endfunction

  // Mostly well-formed traffic for the current link state, with some noise.
  function automatic req_t random_item();
    req_t it;
    int   pick;
    it = tick();
    pick = $urandom_range(99);
    if (pick < 45 || pick >= 92) begin
      if (pick >= 92) it.cmd = 1'($urandom_range(1));
    end else if (board.waiting) begin
      it.cmd = KIND_PACKET;
      it.rx_seq = board.pending_seq;
      if (pick < 70) begin
        it.rx_type = RX_ACK;
      end else if (pick < 80) begin
        it.rx_type = RX_NAK;
      end else if (pick < 86) begin
        it.rx_type = ($urandom_range(1) != 0) ? RX_ACK : RX_NAK;
        it.rx_seq = board.pending_seq ^ (32'd1 << $urandom_range(31));
      end else begin
        it.rx_type = ($urandom_range(1) != 0) ? RX_TELEMETRY : RX_COMMAND;
      end
    end else begin
      it.cmd = KIND_PACKET;
      it.rx_crc_ok = ($urandom_range(9) != 0);
      if (pick < 80) begin
        it.rx_type = RX_COMMAND;
        it.rx_payload_ok = ($urandom_range(4) != 0);
        case ($urandom_range(3))
          0: it.rx_seq = board.expected_rx;
          1: it.rx_seq = board.expected_rx + $urandom_range(1, 3);
          2: it.rx_seq = board.expected_rx - $urandom_range(1, 3);
          default: ;
        endcase
      end
    end
    return it;
  endfunction

  task automatic send_item(input req_t it);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= it.cmd;
    req.rx_type <= it.rx_type;
    req.rx_seq <= it.rx_seq;
    req.rx_crc_ok <= it.rx_crc_ok;
    req.rx_payload_ok <= it.rx_payload_ok;
    req.rx_command <= it.rx_command;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic quiesce();
    req.valid <= 1'b0;
    @(negedge clk);
    while (board.due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int unsigned phase_retries[NumPhases] = '{0, 15, 2, 5, 1, 15, 7, 3};
    int unsigned phase_timeout[NumPhases] = '{1, 3, 0, 6, 2, 65535, 4, 5};
    int unsigned phase_period[NumPhases] = '{1, 4, 0, 8, 3, 2, 65535, 6};
    int          send_idle[4] = '{0, 67, 0, 22};
    int          recv_stall[4] = '{0, 0, 67, 22};

    rst = 1'b1;
    req.valid = 1'b0;
    req.cmd = KIND_TICK;
    req.rx_type = RX_TELEMETRY;
    req.rx_seq = '0;
    req.rx_crc_ok = 1'b0;
    req.rx_payload_ok = 1'b0;
    req.rx_command = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_MAX_RETRIES;
    cfg.data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: one retry, timeout of two ticks, telemetry every tick.
    write_reg(CFG_MAX_RETRIES, 16'd1);
    write_reg(CFG_ACK_TIMEOUT, 16'd2);
    write_reg(CFG_PERIOD, 16'd1);
    // Idle packets: bad checksum is NAKed, good non-commands are dropped.
    send_item(pkt(RX_TELEMETRY, 32'hFFFF_FFFF, 1'b0, 1'b1, 2'd0));
    send_item(pkt(RX_TELEMETRY, 32'd7, 1'b1, 1'b1, 2'd1));
    send_item(pkt(RX_ACK, 32'd0, 1'b1, 1'b0, 2'd2));
    // Commands: new, duplicate, undecodable, and the receive sequence wrapping.
    send_item(pkt(RX_COMMAND, 32'd5, 1'b1, 1'b1, 2'd3));
    send_item(pkt(RX_COMMAND, 32'd3, 1'b1, 1'b1, 2'd2));
    send_item(pkt(RX_COMMAND, 32'd6, 1'b1, 1'b0, 2'd1));
    send_item(pkt(RX_COMMAND, 32'hFFFF_FFFF, 1'b1, 1'b1, 2'd0));
    send_item(pkt(RX_COMMAND, 32'd0, 1'b1, 1'b1, 2'd2));
    // Telemetry acknowledged even though its checksum is bad.
    send_item(tick());
    send_item(pkt(RX_ACK, 32'd0, 1'b0, 1'b0, 2'd0));
    // A matching NAK forces a resend, then a stray command exhausts the retries.
    send_item(tick());
    send_item(pkt(RX_NAK, 32'd1, 1'b1, 1'b1, 2'd0));
    send_item(pkt(RX_COMMAND, 32'd9, 1'b1, 1'b1, 2'd1));
    // Timeouts: resend after two ticks, failure after two more.
    repeat (5) send_item(tick());
    // A wrong sequence resends, the right one completes the send.
    send_item(tick());
    send_item(pkt(RX_ACK, 32'd4, 1'b1, 1'b1, 2'd0));
    send_item(pkt(RX_ACK, 32'd3, 1'b1, 1'b1, 2'd0));
    quiesce();

    // Random part: one register setting and one idling pattern per phase.
    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1) begin
        phase_retries[p] = $urandom_range(15);
        phase_timeout[p] = $urandom_range(1, 12);
        phase_period[p] = $urandom_range(1, 12);
      end
      write_reg(CFG_MAX_RETRIES, 16'(phase_retries[p]));
      write_reg(CFG_ACK_TIMEOUT, 16'(phase_timeout[p]));
      write_reg(CFG_PERIOD, 16'(phase_period[p]));
      idle_pct = send_idle[p % 4];
      stall_pct = recv_stall[p % 4];
      repeat (ItemsPerPhase) send_item(random_item());
      quiesce();
    end

    $display("Ran %0d ticks and packet headers over %0d register settings, %0d results checked.",
             n_sent, NumPhases + 1, board.checked);
    $display("Link saw %0d deliveries, %0d resends, %0d NAKs and %0d accepted commands.",
             board.delivered, board.resends, board.naks, board.accepted);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### stop_and_wait_arq_endpoint.f
sv/saw_arq_pkg.sv
sv/saw_arq_if.sv
sv/saw_arq_step.sv
sv/stop_and_wait_arq_endpoint.sv
tb/tb_stop_and_wait_arq_endpoint.sv
